@@ hw/rtl/bbea_pkg.sv @@
// Shared constants, types and the divisor table of the 3x3 box blur.
`timescale 1ns / 1ps

package bbea_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 4096;

    localparam int CHAN_W       = 8;
    localparam int WID_W        = 11;
    localparam int HGT_W        = 13;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int OROW_W       = $clog2(MAX_HEIGHT);
    localparam int ROW_W        = OROW_W + 1;

    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 13;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(1024);
    localparam logic [HGT_W-1:0] HEIGHT_RESET = HGT_W'(768);

    localparam int SUM_W        = 12;
    localparam int CNT_W        = 4;
    localparam int RECIP_SHIFT  = 16;
    localparam int RECIP_W      = RECIP_SHIFT + 1;
    localparam int PROD_W       = SUM_W + RECIP_W;

    localparam int FIFO_DEPTH   = 8;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FILL_W       = FIFO_PTR_W + 2;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic top;
        logic bot;
        logic left;
        logic right;
    } t_mask;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              last;
    } t_res;

    // ceil(2^16 / count); exact quotient for every rounded sum of nine bytes
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] m;
        unique case (cnt)
            CNT_W'(1): m = RECIP_W'(65536);
            CNT_W'(2): m = RECIP_W'(32768);
            CNT_W'(3): m = RECIP_W'(21846);
            CNT_W'(4): m = RECIP_W'(16384);
            CNT_W'(6): m = RECIP_W'(10923);
            CNT_W'(9): m = RECIP_W'(7282);
            default:   m = '0;
        endcase
        return m;
    endfunction

endpackage

@@ hw/rtl/bbea_if.sv @@
// Valid/ready channel interfaces of the 3x3 box blur: pixel in, result out, register write.
`timescale 1ns / 1ps

interface bbea_pix_if;
    import bbea_pkg::*;
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [CHAN_W-1:0] in_red;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_blue;
    modport source (output valid, req_type, in_red, in_green, in_blue, input ready);
    modport sink   (input valid, req_type, in_red, in_green, in_blue, output ready);
endinterface

interface bbea_res_if;
    import bbea_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic              out_last;
    modport source (output valid, out_red, out_green, out_blue, out_last, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, out_last, output ready);
endinterface

interface bbea_cfg_if;
    import bbea_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/box_blur_3x3_edge_aware.sv @@
// Top level of the edge-aware 3x3 box blur over an RGB raster stream.
//
// Usage:
//   i_pix carries one transaction per pixel (req_type 0) or per drain request
//   (req_type 1). After the last pixel of a frame, frame_width + 1 drains flush
//   the outputs still held back; drains before the frame is complete do nothing.
//   o_res delivers one transaction per output pixel, out_last marks the final
//   one. i_cfg writes frame_width (index 0) and frame_height (index 1); write
//   only while idle. A write restarts the frame position.
// Throughput and pipeline:
//   One transaction per cycle while i_pix.ready is high. After the transaction
//   that completes its neighborhood, a result moves through line buffer read at
//   accept, window update, sum and reciprocal multiply into the output queue.
//   Consecutive transactions at the same line buffer column are forwarded.
// Reset:
//   Size registers return to 1024 x 768, positions and queue clear. The line
//   buffers are not cleared; out-of-frame neighbors are never summed.
// Stall:
//   An 8-entry output queue absorbs the pipeline; i_pix.ready drops once the
//   queue plus results in flight reach its depth.
`timescale 1ns / 1ps

module box_blur_3x3_edge_aware (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bbea_pix_if.sink   i_pix,
    bbea_res_if.source o_res,
    bbea_cfg_if.sink   i_cfg
);
    import bbea_pkg::*;

    logic [WID_W-1:0]  r_frame_width;
    logic [HGT_W-1:0]  r_frame_height;
    logic [WID_W-1:0]  w_eff;
    logic [HGT_W-1:0]  h_eff;

    logic [COL_W-1:0]  r_in_col;
    logic [ROW_W-1:0]  r_in_row;
    logic [COL_W-1:0]  r_out_col;
    logic [OROW_W-1:0] r_out_row;
    logic              r_all_in;

    logic              cfg_fire;
    logic              pix_fire;
    logic              item_ok;
    logic              in_col_wrap;
    logic [ROW_W-1:0]  in_row_inc;
    logic              emit;
    logic              out_col_last;
    logic              out_row_last;
    logic              last;
    t_mask             mask;
    t_rgb              pix;

    t_rgb              r_line_above [MAX_WIDTH];
    t_rgb              r_line_two   [MAX_WIDTH];
    t_rgb              r_rd_top;
    t_rgb              r_rd_mid;

    logic              r_s1_valid;
    logic              r_s1_emit;
    t_rgb              r_s1_pix;
    logic [COL_W-1:0]  r_s1_col;
    t_mask             r_s1_mask;
    logic              r_s1_last;
    logic              r_s1_fwd;
    t_rgb              r_fwd_top;
    t_rgb              r_fwd_mid;
    t_rgb              s1_top;
    t_rgb              s1_mid;

    t_rgb              r_win [9];

    logic              r_s2_valid;
    t_mask             r_s2_mask;
    logic              r_s2_last;
    logic [SUM_W-1:0]  s2_sum_r;
    logic [SUM_W-1:0]  s2_sum_g;
    logic [SUM_W-1:0]  s2_sum_b;
    logic [CNT_W-1:0]  s2_cnt;
    logic [CNT_W-1:0]  s2_half;

    logic              r_s3_valid;
    logic [SUM_W-1:0]  r_s3_x_r;
    logic [SUM_W-1:0]  r_s3_x_g;
    logic [SUM_W-1:0]  r_s3_x_b;
    logic [RECIP_W-1:0] r_s3_recip;
    logic              r_s3_last;
    logic [PROD_W-1:0] s3_prod_r;
    logic [PROD_W-1:0] s3_prod_g;
    logic [PROD_W-1:0] s3_prod_b;
    t_res              s3_res;

    t_res              r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FILL_W-1:0] r_fifo_cnt;
    logic [FILL_W-1:0] fill;
    logic              push;
    logic              pop;

    // effective frame size
    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = WID_W'(1);
        end else if (r_frame_width > WID_W'(MAX_WIDTH)) begin
            w_eff = WID_W'(MAX_WIDTH);
        end else begin
            w_eff = r_frame_width;
        end
        if (r_frame_height == '0) begin
            h_eff = HGT_W'(1);
        end else if (r_frame_height > HGT_W'(MAX_HEIGHT)) begin
            h_eff = HGT_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_frame_height;
        end
    end

    assign cfg_fire    = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;

    assign pix_fire = i_pix.valid && i_pix.ready;
    assign item_ok  = pix_fire && !(i_pix.req_type && !r_all_in);
    assign pix      = r_all_in ? '0 : t_rgb'{i_pix.in_red, i_pix.in_green, i_pix.in_blue};

    assign in_col_wrap  = (WID_W'(r_in_col) + WID_W'(1)) >= w_eff;
    assign in_row_inc   = r_in_row + ROW_W'(1);
    assign emit         = (r_in_row >= ROW_W'(2)) ||
                          ((r_in_row == ROW_W'(1)) && (r_in_col != '0));
    assign out_col_last = (WID_W'(r_out_col) + WID_W'(1)) >= w_eff;
    assign out_row_last = (HGT_W'(r_out_row) + HGT_W'(1)) >= h_eff;
    assign last         = out_row_last && out_col_last;
    assign mask         = t_mask'{(r_out_row != '0), !out_row_last,
                                  (r_out_col != '0), !out_col_last};

    // frame position and size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
            r_in_col       <= '0;
            r_in_row       <= '0;
            r_out_col      <= '0;
            r_out_row      <= '0;
            r_all_in       <= 1'b0;
        end else if (cfg_fire) begin
            if (i_cfg.index == REG_FRAME_WIDTH) begin
                r_frame_width <= i_cfg.data[WID_W-1:0];
            end
            if (i_cfg.index == REG_FRAME_HEIGHT) begin
                r_frame_height <= i_cfg.data[HGT_W-1:0];
            end
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_all_in  <= 1'b0;
        end else if (item_ok) begin
            if (emit && last) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
                r_all_in  <= 1'b0;
            end else begin
                if (in_col_wrap) begin
                    r_in_col <= '0;
                    r_in_row <= in_row_inc;
                    if (!r_all_in && (in_row_inc >= ROW_W'(h_eff))) begin
                        r_all_in <= 1'b1;
                    end
                end else begin
                    r_in_col <= r_in_col + COL_W'(1);
                end
                if (emit) begin
                    if (out_col_last) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + OROW_W'(1);
                    end else begin
                        r_out_col <= r_out_col + COL_W'(1);
                    end
                end
            end
        end
    end

    // line buffers: read on accept, write back in the next cycle
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_line_above[r_s1_col] <= r_s1_pix;
            r_line_two[r_s1_col]   <= s1_mid;
        end
        if (item_ok) begin
            r_rd_top <= r_line_two[r_in_col];
            r_rd_mid <= r_line_above[r_in_col];
        end
    end

    assign s1_top = r_s1_fwd ? r_fwd_top : r_rd_top;
    assign s1_mid = r_s1_fwd ? r_fwd_mid : r_rd_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_emit  <= 1'b0;
        end else begin
            r_s1_valid <= item_ok;
            r_s1_emit  <= item_ok && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (item_ok) begin
            r_s1_pix  <= pix;
            r_s1_col  <= r_in_col;
            r_s1_mask <= mask;
            r_s1_last <= last;
            r_s1_fwd  <= r_s1_valid && (r_s1_col == r_in_col);
            r_fwd_top <= s1_mid;
            r_fwd_mid <= r_s1_pix;
        end
    end

    // 3x3 window: shift left, new column on the right
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (r_s1_valid) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]   <= r_win[r*3+1];
                r_win[r*3+1] <= r_win[r*3+2];
            end
            r_win[2] <= s1_top;
            r_win[5] <= s1_mid;
            r_win[8] <= r_s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_s2_mask <= r_s1_mask;
            r_s2_last <= r_s1_last;
        end
    end

    // masked neighborhood sums
    always_comb begin
        s2_sum_r = '0;
        s2_sum_g = '0;
        s2_sum_b = '0;
        s2_cnt   = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (((r != 0) || r_s2_mask.top) && ((r != 2) || r_s2_mask.bot) &&
                    ((c != 0) || r_s2_mask.left) && ((c != 2) || r_s2_mask.right)) begin
                    s2_sum_r = s2_sum_r + SUM_W'(r_win[r*3+c].red);
                    s2_sum_g = s2_sum_g + SUM_W'(r_win[r*3+c].green);
                    s2_sum_b = s2_sum_b + SUM_W'(r_win[r*3+c].blue);
                    s2_cnt   = s2_cnt + CNT_W'(1);
                end
            end
        end
        s2_half = s2_cnt >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_s3_x_r   <= s2_sum_r + SUM_W'(s2_half);
            r_s3_x_g   <= s2_sum_g + SUM_W'(s2_half);
            r_s3_x_b   <= s2_sum_b + SUM_W'(s2_half);
            r_s3_recip <= recip(s2_cnt);
            r_s3_last  <= r_s2_last;
        end
    end

    // divide by reciprocal multiply
    assign s3_prod_r = PROD_W'(r_s3_x_r) * PROD_W'(r_s3_recip);
    assign s3_prod_g = PROD_W'(r_s3_x_g) * PROD_W'(r_s3_recip);
    assign s3_prod_b = PROD_W'(r_s3_x_b) * PROD_W'(r_s3_recip);
    assign s3_res    = t_res'{s3_prod_r[RECIP_SHIFT +: CHAN_W],
                              s3_prod_g[RECIP_SHIFT +: CHAN_W],
                              s3_prod_b[RECIP_SHIFT +: CHAN_W],
                              r_s3_last};

    // output queue
    assign push = r_s3_valid;
    assign pop  = o_res.valid && o_res.ready;
    assign fill = r_fifo_cnt + FILL_W'(r_s1_emit) + FILL_W'(r_s2_valid) + FILL_W'(r_s3_valid);
    assign i_pix.ready = fill < FILL_W'(FIFO_DEPTH);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= s3_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            r_fifo_cnt <= r_fifo_cnt + FILL_W'(push) - FILL_W'(pop);
        end
    end

    assign o_res.valid     = r_fifo_cnt != '0;
    assign o_res.out_red   = r_fifo[r_rd_ptr].red;
    assign o_res.out_green = r_fifo[r_rd_ptr].green;
    assign o_res.out_blue  = r_fifo[r_rd_ptr].blue;
    assign o_res.out_last  = r_fifo[r_rd_ptr].last;

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench of the edge-aware 3x3 box blur: random frames, stalls, register writes.
`timescale 1ns / 1ps

module tb_top;
    import bbea_pkg::*;

    localparam logic REQ_PIXEL    = 1'b0;
    localparam logic REQ_DRAIN    = 1'b1;
    localparam int   SETTLE_CYCLES = 12;
    localparam int   LIMIT_CYCLES  = 1_000_000;
    localparam int   PHASE_ITEMS   = 95;

    class blur_checker;
        t_rgb                 row_above [MAX_WIDTH];
        t_rgb                 row_two_above [MAX_WIDTH];
        t_rgb                 win [9];
        int unsigned          in_col;
        int unsigned          in_row;
        int unsigned          out_col;
        int unsigned          out_row;
        bit                   frame_in;
        logic [WID_W-1:0]     width_reg;
        logic [HGT_W-1:0]     height_reg;
        t_res                 blurred_q [$];
        int                   errors;

        function new();
            foreach (row_above[i]) begin
                row_above[i]     = '0;
                row_two_above[i] = '0;
            end
            foreach (win[i]) win[i] = '0;
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            errors     = 0;
            restart();
        endfunction

        function void restart();
            in_col   = 0;
            in_row   = 0;
            out_col  = 0;
            out_row  = 0;
            frame_in = 1'b0;
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_WIDTH) return MAX_WIDTH;
            return width_reg;
        endfunction

        function int unsigned eff_height();
            if (height_reg == 0) return 1;
            if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
            return height_reg;
        endfunction

        // register write: abort the frame; pending outputs stay queued
        function void note_reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_FRAME_WIDTH) width_reg = data[WID_W-1:0];
            if (idx == REG_FRAME_HEIGHT) height_reg = data[HGT_W-1:0];
            restart();
        endfunction

        function void note_item(logic drain, t_rgb px);
            int unsigned       w;
            int unsigned       h;
            int unsigned       col;
            longint unsigned   k;
            t_rgb              pix;
            t_rgb              top;
            t_rgb              mid;
            t_rgb              v;
            int unsigned       sum_r;
            int unsigned       sum_g;
            int unsigned       sum_b;
            int unsigned       cnt;
            bit                at_end;
            t_res              res;
            w = eff_width();
            h = eff_height();
            if (!frame_in && drain) return;
            pix = frame_in ? t_rgb'(0) : px;
            col = in_col;
            top = row_two_above[col];
            mid = row_above[col];
            row_two_above[col] = mid;
            row_above[col]     = pix;
            for (int r = 0; r < 3; r++) begin
                win[r*3]   = win[r*3+1];
                win[r*3+1] = win[r*3+2];
            end
            win[2] = top;
            win[5] = mid;
            win[8] = pix;
            k = longint'(in_row) * w + in_col;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
                if (!frame_in && in_row >= h) frame_in = 1'b1;
            end
            if (k < w + 1) return;
            sum_r  = 0;
            sum_g  = 0;
            sum_b  = 0;
            cnt    = 0;
            at_end = (out_row + 1 >= h) && (out_col + 1 >= w);
            for (int r = 0; r < 3; r++) begin
                if ((r == 0 && out_row == 0) || (r == 2 && out_row + 1 >= h)) continue;
                for (int c = 0; c < 3; c++) begin
                    if ((c == 0 && out_col == 0) || (c == 2 && out_col + 1 >= w)) continue;
                    v = win[r*3+c];
                    sum_r += v.red;
                    sum_g += v.green;
                    sum_b += v.blue;
                    cnt++;
                end
            end
            res.red   = CHAN_W'((sum_r + cnt / 2) / cnt);
            res.green = CHAN_W'((sum_g + cnt / 2) / cnt);
            res.blue  = CHAN_W'((sum_b + cnt / 2) / cnt);
            res.last  = at_end;
            blurred_q.push_back(res);
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
            if (at_end) restart();
        endfunction

        function void check_result(t_res act);
            t_res exp_res;
            if (blurred_q.size() == 0) begin
                errors++;
                $display("%0t unexpected result: expected none, actual r=%0d g=%0d b=%0d last=%0b",
                         $time, act.red, act.green, act.blue, act.last);
                return;
            end
            exp_res = blurred_q.pop_front();
            if (act !== exp_res) begin
                errors++;
                $write("%0t mismatch: expected r=%0d g=%0d b=%0d last=%0b,",
                       $time, exp_res.red, exp_res.green, exp_res.blue, exp_res.last);
                $display(" actual r=%0d g=%0d b=%0d last=%0b",
                         act.red, act.green, act.blue, act.last);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    int          idle_pct;
    int          stall_pct;
    int          fed_items;
    int          cycle_cnt = 0;
    blur_checker chk;

    bbea_pix_if pix_ch ();
    bbea_res_if res_ch ();
    bbea_cfg_if cfg_ch ();

    box_blur_3x3_edge_aware i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch.sink),
        .o_res   (res_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            chk.check_result({res_ch.out_red, res_ch.out_green, res_ch.out_blue, res_ch.out_last});
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("[box_blur_3x3_edge_aware] ERROR");
            $finish;
        end
    end

    task automatic send_item(input logic req, input t_rgb px);
        while ($urandom_range(99) < idle_pct) begin
            pix_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_ch.valid    <= 1'b1;
        pix_ch.req_type <= req;
        pix_ch.in_red   <= px.red;
        pix_ch.in_green <= px.green;
        pix_ch.in_blue  <= px.blue;
        do @(posedge i_clk); while (pix_ch.ready !== 1'b1);
        chk.note_item(req, px);
    endtask

    // hold off until every pending output is out and the pipeline is empty
    task automatic settle();
        pix_ch.valid <= 1'b0;
        while (chk.blurred_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        chk.note_reg_write(idx, data);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h);
        settle();
        write_reg(REG_FRAME_WIDTH, {2'($urandom_range(3)), WID_W'(w)});
        write_reg(REG_FRAME_HEIGHT, HGT_W'(h));
    endtask

    // full frame, then width + 1 drains; noise adds ignored drains and swaps some drains for pixels
    task automatic feed_frame(input int unsigned w, input int unsigned h, input int noise);
        for (int unsigned i = 0; i < w * h; i++) begin
            if ($urandom_range(99) < noise) send_item(REQ_DRAIN, t_rgb'($urandom));
            send_item(REQ_PIXEL, t_rgb'($urandom));
        end
        for (int unsigned i = 0; i < w + 1; i++)
            send_item(($urandom_range(99) < noise) ? REQ_PIXEL : REQ_DRAIN, t_rgb'($urandom));
        if ($urandom_range(99) < noise) send_item(REQ_DRAIN, t_rgb'($urandom));
        fed_items += w * h + w + 1;
    endtask

    initial begin
        int unsigned w;
        int unsigned h;
        int unsigned m;
        t_rgb        px;
        chk             = new();
        idle_pct        = 0;
        stall_pct       = 0;
        fed_items       = 0;
        i_rst_n         <= 1'b0;
        pix_ch.valid    <= 1'b0;
        pix_ch.req_type <= REQ_PIXEL;
        pix_ch.in_red   <= '0;
        pix_ch.in_green <= '0;
        pix_ch.in_blue  <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= REG_FRAME_WIDTH;
        cfg_ch.data     <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 3x3 frame of black, white and random columns with stray drains and a pixel in the drain phase
        set_frame(3, 3);
        send_item(REQ_DRAIN, t_rgb'($urandom));
        for (int i = 0; i < 9; i++) begin
            px = (i % 3 == 0) ? 24'h000000 : (i % 3 == 1) ? 24'hFFFFFF : t_rgb'($urandom);
            send_item(REQ_PIXEL, px);
        end
        send_item(REQ_PIXEL, 24'hFFFFFF);
        repeat (3) send_item(REQ_DRAIN, t_rgb'($urandom));
        send_item(REQ_DRAIN, t_rgb'($urandom));

        // zero sizes clamp to a single pixel
        set_frame(0, 0);
        send_item(REQ_PIXEL, 24'hFF00FF);
        repeat (2) send_item(REQ_DRAIN, 24'h00FF00);

        // single row
        set_frame(3, 1);
        feed_frame(3, 1, 0);

        // abort a frame in progress
        set_frame(4, 3);
        repeat (6) send_item(REQ_PIXEL, t_rgb'($urandom));
        settle();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 50; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 50; end
                default: begin idle_pct = 17; stall_pct = 17; end
            endcase
            fed_items = 0;
            while (fed_items < PHASE_ITEMS) begin
                w = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
                h = $urandom_range(1, 5);
                set_frame(w, h);
                if ($urandom_range(7) == 0 && w * h > 1) begin
                    m = $urandom_range(1, w * h - 1);
                    repeat (m) send_item(REQ_PIXEL, t_rgb'($urandom));
                    fed_items += m;
                    settle();
                end else begin
                    feed_frame(w, h, 8);
                end
            end
        end

        // oversized registers: short partial frames under the clamped sizes
        idle_pct  = 10;
        stall_pct = 10;
        set_frame(2047, 2);
        repeat (4) send_item(REQ_PIXEL, t_rgb'($urandom));
        set_frame(1, 8191);
        repeat (8) send_item(REQ_PIXEL, t_rgb'($urandom));
        set_frame(MAX_WIDTH, MAX_HEIGHT);

        settle();
        if (chk.errors == 0)
            $display("[box_blur_3x3_edge_aware] OK");
        else
            $display("[box_blur_3x3_edge_aware] ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/bbea_pkg.sv
hw/rtl/bbea_if.sv
hw/rtl/box_blur_3x3_edge_aware.sv
dv/tb_top.sv
